>>> hdl/nerc_pkg.sv
// Package for the nearest exon region classifier.
// Holds field widths, the exon index limit, region class codes and payload types.
// No dependencies.
`timescale 1ns / 1ps

package nerc_pkg;

	localparam int COORD_W   = 31;
	localparam int INDEX_W   = 10;
	localparam int CLASS_W   = 2;
	localparam int MAX_EXONS = 1024;

	// Exon index saturates at the smaller of MAX_EXONS-1 and the index field's maximum.
	localparam int INDEX_FIELD_MAX = (1 << INDEX_W) - 1;
	localparam int INDEX_CAP_INT   = (MAX_EXONS - 1 < INDEX_FIELD_MAX) ?
		(MAX_EXONS - 1) : INDEX_FIELD_MAX;
	localparam logic [INDEX_W-1:0] INDEX_CAP = INDEX_CAP_INT[INDEX_W-1:0];

	// Region class codes
	localparam logic [CLASS_W-1:0] CLASS_UTR5   = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_UTR3   = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_INTRON = 2'd2;

	typedef struct packed {
		logic [COORD_W-1:0] query_start;
		logic [COORD_W-1:0] query_end;
		logic [COORD_W-1:0] exon_start;
		logic [COORD_W-1:0] exon_end;
		logic               minus_strand;
		logic               last_exon;
	} exon_item_t;

	typedef struct packed {
		logic [CLASS_W-1:0] region_class;
		logic [INDEX_W-1:0] nearest_index;
		logic [COORD_W-1:0] nearest_distance;
	} region_item_t;

endpackage

>>> hdl/nerc_if.sv
// Valid/ready channel interfaces for the nearest exon region classifier.
// Depends on nerc_pkg for the payload types.
`timescale 1ns / 1ps

interface nerc_exon_if import nerc_pkg::*; ();
	logic       valid;
	logic       ready;
	exon_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface nerc_region_if import nerc_pkg::*; ();
	logic         valid;
	logic         ready;
	region_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hdl/nearest_exon_region_classifier.sv
// Nearest exon region classifier: takes the exons of one transcript, one item per
// cycle, and emits one region class item on the exon marked last. The exon channel
// accepts an item every cycle while the result side keeps up; the input stage forms
// the exon-to-query distance and registers it, the second stage folds it into the
// running minimum and loads the result register, so a last exon reaches the output
// through the stage 1 and result registers. Only a stalled result held over a further last
// exon stops the exon channel. Exon indexes saturate at 1023; after a last exon the
// block starts a new transcript at index 0.
// Depends on nerc_pkg and the channel interfaces in nerc_if.sv.
`timescale 1ns / 1ps

module nearest_exon_region_classifier import nerc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	nerc_exon_if.sink            exon,
	nerc_region_if.source        result
);

	// Stage 1 registers
	logic               valid_s1;
	logic [COORD_W-1:0] dist_s1;
	logic               minus_s1;
	logic               last_s1;

	// Running state
	logic [INDEX_W-1:0] exon_count_q;
	logic [COORD_W-1:0] best_dist_q;
	logic [INDEX_W-1:0] best_index_q;

	// Result register
	logic               res_valid_q;
	region_item_t       res_data_q;

	logic               exon_fire;
	logic               out_free;
	logic               adv_s1;
	logic [COORD_W-1:0] diff_end;
	logic [COORD_W-1:0] diff_start;
	logic [COORD_W-1:0] dist_in;
	logic               take;
	logic [COORD_W-1:0] best_dist_new;
	logic [INDEX_W-1:0] best_index_new;
	logic [CLASS_W-1:0] class_new;
	logic               at_first;
	logic               at_last;

	// Handshake: stage 1 advances unless it holds a last exon and the result is stuck
	assign out_free  = !res_valid_q || result.ready;
	assign adv_s1    = valid_s1 && (!last_s1 || out_free);
	assign exon.ready = !valid_s1 || adv_s1;
	assign exon_fire = exon.valid && exon.ready;

	// Distance from the query to the incoming exon
	always_comb begin
		diff_end = (exon.data.exon_end >= exon.data.query_start) ?
			(exon.data.exon_end - exon.data.query_start) :
			(exon.data.query_start - exon.data.exon_end);
		diff_start = (exon.data.exon_start >= exon.data.query_end) ?
			(exon.data.exon_start - exon.data.query_end) :
			(exon.data.query_end - exon.data.exon_start);
		dist_in = (exon.data.exon_start < exon.data.query_start) ? diff_end : diff_start;
	end

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (exon.ready) begin
			valid_s1 <= exon.valid;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (exon_fire) begin
			dist_s1  <= dist_in;
			minus_s1 <= exon.data.minus_strand;
			last_s1  <= exon.data.last_exon;
		end
	end

	// Fold the distance into the running minimum and classify
	always_comb begin
		take           = (exon_count_q == '0) || (dist_s1 < best_dist_q);
		best_dist_new  = take ? dist_s1 : best_dist_q;
		best_index_new = take ? exon_count_q : best_index_q;
		at_first       = (best_index_new == '0);
		at_last        = (best_index_new == exon_count_q);
		if ((at_first && !minus_s1) || (at_last && minus_s1)) begin
			class_new = CLASS_UTR5;
		end else if ((at_first && minus_s1) || (at_last && !minus_s1)) begin
			class_new = CLASS_UTR3;
		end else begin
			class_new = CLASS_INTRON;
		end
	end

	// Running state: advance on each exon, clear after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exon_count_q <= '0;
			best_dist_q  <= '0;
			best_index_q <= '0;
		end else if (adv_s1) begin
			if (last_s1) begin
				exon_count_q <= '0;
				best_dist_q  <= '0;
				best_index_q <= '0;
			end else begin
				best_dist_q  <= best_dist_new;
				best_index_q <= best_index_new;
				if (exon_count_q < INDEX_CAP) begin
					exon_count_q <= exon_count_q + 1'b1;
				end
			end
		end
	end

	// Result valid: load on a last exon, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv_s1 && last_s1) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			res_data_q.region_class     <= class_new;
			res_data_q.nearest_index    <= best_index_new;
			res_data_q.nearest_distance <= best_dist_new;
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_data_q;

endmodule

>>> dv/nerc_region_check.sv
// Checker for the nearest exon region classifier: watches both channels, predicts each
// region item from the accepted exon items and compares the two field by field.
// Depends on nerc_pkg and the channel interfaces in nerc_if.sv.
`timescale 1ns / 1ps

module nerc_region_check import nerc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	nerc_exon_if   exon,
	nerc_region_if result,
	output int     failures,
	output int     pending,
	output int     exons_seen,
	output int     regions_seen
);

	// Predicted transcript state
	logic [INDEX_W-1:0] next_index;
	logic [COORD_W-1:0] min_distance;
	logic [INDEX_W-1:0] min_index;
	region_item_t       expected_regions[$];

	function automatic logic [COORD_W-1:0] span_between(input logic [COORD_W-1:0] a,
			input logic [COORD_W-1:0] b);
		return (a >= b) ? a - b : b - a;
	endfunction

	// Fold one exon into the running minimum; queue a region item on the last exon
	task automatic fold_exon(input exon_item_t it);
		logic [COORD_W-1:0] exon_gap;
		logic [INDEX_W-1:0] idx;
		region_item_t       r;
		idx = next_index;
		if (it.exon_start < it.query_start) begin
			exon_gap = span_between(it.exon_end, it.query_start);
		end else begin
			exon_gap = span_between(it.exon_start, it.query_end);
		end
		if (idx == '0 || exon_gap < min_distance) begin
			min_distance = exon_gap;
			min_index = idx;
		end
		if (!it.last_exon) begin
			if (next_index < INDEX_CAP) next_index = next_index + 1'b1;
		end else begin
			if ((min_index == '0 && !it.minus_strand) ||
					(min_index == idx && it.minus_strand)) begin
				r.region_class = CLASS_UTR5;
			end else if ((min_index == '0 && it.minus_strand) ||
					(min_index == idx && !it.minus_strand)) begin
				r.region_class = CLASS_UTR3;
			end else begin
				r.region_class = CLASS_INTRON;
			end
			r.nearest_index = min_index;
			r.nearest_distance = min_distance;
			expected_regions.push_back(r);
			next_index = '0;
			min_distance = '0;
			min_index = '0;
		end
	endtask

	// Compare one region item against the oldest prediction
	task automatic check_region(input region_item_t got);
		region_item_t want;
		if (expected_regions.size() == 0) begin
			$error("unexpected region item: class %0d index %0d distance %0d",
				got.region_class, got.nearest_index, got.nearest_distance);
			failures++;
		end else begin
			want = expected_regions.pop_front();
			if (got.region_class !== want.region_class) begin
				$error("region_class: expected %0d, actual %0d", want.region_class,
					got.region_class);
				failures++;
			end
			if (got.nearest_index !== want.nearest_index) begin
				$error("nearest_index: expected %0d, actual %0d", want.nearest_index,
					got.nearest_index);
				failures++;
			end
			if (got.nearest_distance !== want.nearest_distance) begin
				$error("nearest_distance: expected %0d, actual %0d", want.nearest_distance,
					got.nearest_distance);
				failures++;
			end
		end
	endtask

	// Sample both channels at each rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_index = '0;
			min_distance = '0;
			min_index = '0;
			expected_regions.delete();
			failures = 0;
			exons_seen = 0;
			regions_seen = 0;
		end else begin
			if (exon.valid && exon.ready) begin
				fold_exon(exon.data);
				exons_seen++;
			end
			if (result.valid && result.ready) begin
				check_region(result.data);
				regions_seen++;
			end
		end
		pending = expected_regions.size();
	end

endmodule

>>> dv/nearest_exon_region_classifier_test.sv
// Testbench top for the nearest exon region classifier: drives directed, long and random
// transcripts with idle and stall phases, and reports the checker's verdict.
// Depends on nerc_pkg, nerc_if.sv, the block and nerc_region_check.
`timescale 1ns / 1ps

module nearest_exon_region_classifier_test;
	import nerc_pkg::*;

	localparam int                 CYCLE_LIMIT = 400000;
	localparam int                 EXON_TARGET = 1650;
	localparam int                 LONG_EXONS  = 1030;
	localparam int                 ZERO_AT     = 1026;
	localparam logic [COORD_W-1:0] COORD_MAX   = {COORD_W{1'b1}};

	typedef enum int {PH_STEADY, PH_SEND_IDLE, PH_RECV_STALL, PH_BOTH} phase_t;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_stall_pct;
	int   cycle_count;
	int   exons_sent;
	int   failures;
	int   pending;
	int   exons_seen;
	int   regions_seen;

	nerc_exon_if   exon_ch ();
	nerc_region_if region_ch ();

	nearest_exon_region_classifier dut (
		.clk    (clk),
		.arst_n (arst_n),
		.exon   (exon_ch),
		.result (region_ch)
	);

	nerc_region_check check (
		.clk          (clk),
		.arst_n       (arst_n),
		.exon         (exon_ch),
		.result       (region_ch),
		.failures     (failures),
		.pending      (pending),
		.exons_seen   (exons_seen),
		.regions_seen (regions_seen)
	);

	// Clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Receiver side: stall at random per phase
	always @(posedge clk) begin
		region_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Hard stop on a hang
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("cycle limit reached with %0d region items outstanding", pending);
			$display("nearest_exon_region_classifier_test NOT OK");
			$finish;
		end
	end

	task automatic set_phase(input phase_t ph);
		case (ph)
			PH_STEADY: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			PH_SEND_IDLE: begin
				send_idle_pct = 78;
				recv_stall_pct = 0;
			end
			PH_RECV_STALL: begin
				send_idle_pct = 0;
				recv_stall_pct = 78;
			end
			default: begin
				send_idle_pct = 14;
				recv_stall_pct = 14;
			end
		endcase
	endtask

	// Offer one exon item after a random idle gap and hold it until accepted
	task automatic push_exon(input logic [COORD_W-1:0] qs, input logic [COORD_W-1:0] qe,
			input logic [COORD_W-1:0] es, input logic [COORD_W-1:0] ee,
			input logic minus, input logic last);
		exon_item_t it;
		it.query_start = qs;
		it.query_end = qe;
		it.exon_start = es;
		it.exon_end = ee;
		it.minus_strand = minus;
		it.last_exon = last;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			exon_ch.valid <= 1'b0;
			@(posedge clk);
		end
		exon_ch.valid <= 1'b1;
		exon_ch.data <= it;
		@(posedge clk);
		while (!exon_ch.ready) @(posedge clk);
		exons_sent++;
	endtask

	function automatic logic [COORD_W-1:0] pick_coord(input bit wide,
			input logic [COORD_W-1:0] base, input int span, input int grain);
		logic [31:0] raw;
		raw = $urandom();
		if (wide) return raw[COORD_W-1:0];
		return base + COORD_W'($urandom_range(0, span / grain) * grain);
	endfunction

	// Hand-picked transcripts: classes, both distance branches, ties, extremes
	task automatic directed_transcripts();
		// single exon on either strand
		push_exon(100, 200, 300, 400, 1'b0, 1'b1);
		push_exon(0, 0, COORD_MAX, COORD_MAX, 1'b1, 1'b1);
		push_exon(COORD_MAX, COORD_MAX, 0, 0, 1'b0, 1'b1);
		push_exon(COORD_MAX, 0, 0, COORD_MAX, 1'b1, 1'b1);
		// middle exon nearest, plus then minus
		push_exon(1000, 1100, 0, 100, 1'b0, 1'b0);
		push_exon(1000, 1100, 900, 1050, 1'b0, 1'b0);
		push_exon(1000, 1100, 5000, 6000, 1'b0, 1'b1);
		push_exon(1000, 1100, 0, 100, 1'b1, 1'b0);
		push_exon(1000, 1100, 900, 1050, 1'b1, 1'b0);
		push_exon(1000, 1100, 5000, 6000, 1'b1, 1'b1);
		// last exon nearest, plus then minus
		push_exon(500, 600, 0, 10, 1'b0, 1'b0);
		push_exon(500, 600, 610, 700, 1'b0, 1'b1);
		push_exon(500, 600, 0, 10, 1'b1, 1'b0);
		push_exon(500, 600, 610, 700, 1'b1, 1'b1);
		// first exon nearest on minus
		push_exon(500, 600, 480, 490, 1'b1, 1'b0);
		push_exon(500, 600, 2000, 2100, 1'b1, 1'b1);
		// equal distances: the first exon keeps the minimum
		push_exon(500, 600, 0, 490, 1'b0, 1'b0);
		push_exon(500, 600, 610, 620, 1'b0, 1'b0);
		push_exon(500, 600, 610, 900, 1'b0, 1'b1);
		// exon start equal to query start, then a zero distance on the last exon
		push_exon(500, 900, 500, 2000, 1'b0, 1'b0);
		push_exon(500, 900, 100, 950, 1'b0, 1'b0);
		push_exon(500, 900, 900, 901, 1'b0, 1'b1);
		// strand and query change inside the transcript
		push_exon(7000, 7100, 100, 200, 1'b1, 1'b0);
		push_exon(3000, 3100, 3100, 3200, 1'b0, 1'b1);
	endtask

	// Transcript past the index cap; its strict minimum sits after the cap
	task automatic long_transcript();
		logic [COORD_W-1:0] q;
		logic [COORD_W-1:0] es;
		logic [COORD_W-1:0] ee;
		q = COORD_W'($urandom_range(100, 32'h7FF0_0000));
		for (int i = 0; i < LONG_EXONS; i++) begin
			if (i == ZERO_AT) begin
				es = q;
				ee = q + COORD_W'(5);
			end else begin
				es = q + COORD_W'(1) + COORD_W'($urandom_range(0, 1000));
				ee = es + COORD_W'($urandom_range(0, 500));
			end
			push_exon(q, q, es, ee, 1'b0, i == LONG_EXONS - 1);
		end
	endtask

	// Random transcript: local or full-range coordinates, a few with drifting query
	task automatic random_transcript();
		int                 len;
		int                 grain;
		bit                 wide;
		bit                 drift;
		logic [COORD_W-1:0] base;
		logic [COORD_W-1:0] qs;
		logic [COORD_W-1:0] qe;
		logic [COORD_W-1:0] es;
		logic [COORD_W-1:0] ee;
		logic               minus;
		len = ($urandom_range(99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 40);
		wide = ($urandom_range(99) < 30);
		drift = ($urandom_range(99) < 10);
		grain = $urandom_range(1) ? 1 : 100;
		base = COORD_W'($urandom_range(0, 32'h7FFF_0000));
		qs = '0;
		qe = '0;
		minus = 1'b0;
		for (int i = 0; i < len; i++) begin
			if (i == 0 || drift) begin
				qs = pick_coord(wide, base, 5000, grain);
				qe = wide ? pick_coord(wide, base, 0, 1) :
					qs + COORD_W'($urandom_range(0, 2000 / grain) * grain);
				minus = 1'($urandom_range(1));
			end
			es = pick_coord(wide, base, 12000, grain);
			ee = wide ? pick_coord(wide, base, 0, 1) :
				es + COORD_W'($urandom_range(0, 3000 / grain) * grain);
			push_exon(qs, qe, es, ee, minus, i == len - 1);
		end
	endtask

	// Stimulus and verdict
	initial begin
		int transcripts;
		arst_n = 1'b0;
		exon_ch.valid = 1'b0;
		exon_ch.data = '0;
		exons_sent = 0;
		transcripts = 0;
		set_phase(PH_STEADY);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_transcripts();
		set_phase(PH_BOTH);
		long_transcript();
		while (exons_sent < EXON_TARGET) begin
			set_phase(phase_t'((transcripts / 10) % 4));
			random_transcript();
			transcripts++;
		end
		exon_ch.valid <= 1'b0;

		// Drain, then let the pipeline settle
		set_phase(PH_STEADY);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("sent %0d exon items in %0d random transcripts plus directed and long runs",
			exons_sent, transcripts);
		$display("checked %0d region items, %0d mismatches, %0d region items missing",
			regions_seen, failures, pending);
		if (failures == 0 && pending == 0) begin
			$display("nearest_exon_region_classifier_test OK");
		end else begin
			$display("nearest_exon_region_classifier_test NOT OK");
		end
		$finish;
	end

endmodule
